@@ src/smc_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding-mode controller package
// Widths, register indexes, reset values and sequencer states that are
// shared by the controller, its channel interfaces and its multiplier.
// ----------------------------------------------------------------------------
package smc_pkg;

  // Data path widths.
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 31;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int SATM_W  = 17;

  // Q16.16 constants.
  localparam logic [DATA_W-1:0] ONE_Q16      = 32'h0001_0000;
  localparam logic [PROD_W-1:0] ROUND_HALF   = 64'h0000_0000_0000_8000;
  localparam logic [DATA_W-1:0] ERR_DEADZONE = 32'd655;
  localparam logic [DATA_W-1:0] RAMP_OFF     = 32'hFFFF_FFFF;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0]  RST_SWITCH_LEVEL   = 31'd65536;
  localparam logic [CFG_W-1:0]  RST_LAMBDA_OVER_DT = 31'd65536;
  localparam logic [CFG_W-1:0]  RST_K_STRONG       = 31'd65536;
  localparam logic [CFG_W-1:0]  RST_INV_PHI_STRONG = 31'd65536;
  localparam logic [CFG_W-1:0]  RST_K_SOFT         = 31'd32768;
  localparam logic [CFG_W-1:0]  RST_INV_PHI_SOFT   = 31'd32768;
  localparam logic [CFG_W-1:0]  RST_DRIVE_LIMIT    = 31'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] RST_MAX_STEP       = 32'hFFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    CFG_SWITCH_LEVEL   = 3'd0,
    CFG_LAMBDA_OVER_DT = 3'd1,
    CFG_K_STRONG       = 3'd2,
    CFG_INV_PHI_STRONG = 3'd3,
    CFG_K_SOFT         = 3'd4,
    CFG_INV_PHI_SOFT   = 3'd5,
    CFG_DRIVE_LIMIT    = 3'd6,
    CFG_MAX_STEP       = 3'd7
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIFF,
    ST_SURF,
    ST_SAT,
    ST_SATR,
    ST_GAIN,
    ST_DRIVE,
    ST_RAMP,
    ST_CLAMP
  } state_t;

endpackage

@@ src/smc_in_if.sv @@
// ----------------------------------------------------------------------------
// Sliding-mode controller input channel
// Valid/ready channel that carries one sample: setpoint, measurement and
// feedforward, all signed Q16.16.
// ----------------------------------------------------------------------------
interface smc_in_if;

  logic                                valid;
  logic                                ready;
  logic signed [smc_pkg::DATA_W-1:0]   target;
  logic signed [smc_pkg::DATA_W-1:0]   measure;
  logic signed [smc_pkg::DATA_W-1:0]   feedforward;

  modport source (output valid, output target, output measure, output feedforward,
                  input ready);
  modport sink   (input valid, input target, input measure, input feedforward,
                  output ready);

endinterface

@@ src/smc_out_if.sv @@
// ----------------------------------------------------------------------------
// Sliding-mode controller output channel
// Valid/ready channel that carries one drive result and its status flags.
// ----------------------------------------------------------------------------
interface smc_out_if;

  logic                                valid;
  logic                                ready;
  logic signed [smc_pkg::DATA_W-1:0]   drive;
  logic                                in_dead_band;
  logic                                ramp_limited;
  logic                                clamped;

  modport source (output valid, output drive, output in_dead_band, output ramp_limited,
                  output clamped, input ready);
  modport sink   (input valid, input drive, input in_dead_band, input ramp_limited,
                  input clamped, output ready);

endinterface

@@ src/smc_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 x 32 multiplier with a registered 64-bit product. The
// controller sequencer steers its operands and reads the product in the
// step that follows.
// ----------------------------------------------------------------------------
module smc_mul (
  input  logic                          clk,
  input  logic [smc_pkg::DATA_W-1:0]    a,
  input  logic [smc_pkg::DATA_W-1:0]    b,
  output logic [smc_pkg::PROD_W-1:0]    p
);

  // Product register.
  always_ff @(posedge clk) begin
    p <= smc_pkg::PROD_W'(a) * smc_pkg::PROD_W'(b);
  end

endmodule

@@ src/sliding_mode_controller_step_top.sv @@
// ----------------------------------------------------------------------------
// Sliding-mode controller step
// One control step per sample in Q16.16: error, sliding surface, boundary
// layer saturation, gain, feedforward, ramp limit and output clamp.
// ----------------------------------------------------------------------------
// A sample is accepted only while the sequencer is idle, and the next sample
// only once it has returned to idle; an error inside the dead band skips from
// the error step to the ramp step. The pace is set by the single shared
// 32 x 32 multiplier, which is used three times per sample (surface slope,
// boundary layer scaling and gain), each pass followed by a rounding step.
// The result sits in an output register, so a new sample is taken while the
// previous result still waits; the sequencer only holds in its last step if
// that register is still full. Configuration writes take effect at once and
// must be made while no sample is in flight.
module sliding_mode_controller_step_top (
  input  logic                          clk,
  input  logic                          rst,
  smc_in_if.sink                        in_ch,
  smc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [smc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [smc_pkg::DATA_W-1:0]    cfg_data
);

  // Configuration registers.
  logic [smc_pkg::CFG_W-1:0]  switch_level;
  logic [smc_pkg::CFG_W-1:0]  lambda_over_dt;
  logic [smc_pkg::CFG_W-1:0]  k_strong;
  logic [smc_pkg::CFG_W-1:0]  inv_phi_strong;
  logic [smc_pkg::CFG_W-1:0]  k_soft;
  logic [smc_pkg::CFG_W-1:0]  inv_phi_soft;
  logic [smc_pkg::CFG_W-1:0]  drive_limit;
  logic [smc_pkg::DATA_W-1:0] max_step;

  // Sequencer and controller state.
  smc_pkg::state_t            state;
  smc_pkg::state_t            state_next;
  logic signed [31:0]         prev_err;
  logic signed [31:0]         prev_drive;

  // Sample registers and intermediate results.
  logic signed [31:0]         t_r;
  logic signed [31:0]         m_r;
  logic signed [31:0]         ff_r;
  logic signed [31:0]         err_r;
  logic                       dead_r;
  logic                       strong_r;
  logic                       de_neg_r;
  logic                       s_neg_r;
  logic                       s_zero_r;
  logic                       s_big_r;
  logic [31:0]                smag_lo_r;
  logic                       ip_zero_r;
  logic [smc_pkg::SATM_W-1:0] satm_r;
  logic signed [33:0]         drv_r;
  logic                       ramped_r;

  // Output register.
  logic                       out_valid;
  logic signed [31:0]         drive_q;
  logic                       dead_q;
  logic                       ramped_q;
  logic                       clamped_q;

  // Shared multiplier.
  logic [smc_pkg::DATA_W-1:0] mul_a;
  logic [smc_pkg::DATA_W-1:0] mul_b;
  logic [smc_pkg::PROD_W-1:0] mul_p;
  logic [smc_pkg::PROD_W-1:0] p_rnd;

  // Combinational data path.
  logic signed [32:0]         diff;
  logic signed [31:0]         err_sat;
  logic [31:0]                emag;
  logic signed [32:0]         de;
  logic [32:0]                de_mag;
  logic signed [48:0]         term_s;
  logic signed [48:0]         s_val;
  logic [48:0]                smag;
  logic [smc_pkg::CFG_W-1:0]  ip_sel;
  logic [smc_pkg::CFG_W-1:0]  k_sel;
  logic [47:0]                r_sat;
  logic [smc_pkg::SATM_W-1:0] satm;
  logic signed [33:0]         g_s;
  logic signed [33:0]         drv_sum;
  logic signed [34:0]         delta;
  logic [34:0]                dmag;
  logic signed [33:0]         step_s;
  logic signed [33:0]         lim_s;
  logic signed [31:0]         drv_final;
  logic                       clamp_hit;
  logic                       slot_free;
  logic                       in_accept;

  smc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign in_accept = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid || out_ch.ready;
  assign p_rnd     = mul_p + smc_pkg::ROUND_HALF;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_level   <= smc_pkg::RST_SWITCH_LEVEL;
      lambda_over_dt <= smc_pkg::RST_LAMBDA_OVER_DT;
      k_strong       <= smc_pkg::RST_K_STRONG;
      inv_phi_strong <= smc_pkg::RST_INV_PHI_STRONG;
      k_soft         <= smc_pkg::RST_K_SOFT;
      inv_phi_soft   <= smc_pkg::RST_INV_PHI_SOFT;
      drive_limit    <= smc_pkg::RST_DRIVE_LIMIT;
      max_step       <= smc_pkg::RST_MAX_STEP;
    end else if (cfg_we) begin
      unique case (smc_pkg::cfg_idx_t'(cfg_index))
        smc_pkg::CFG_SWITCH_LEVEL:   switch_level   <= cfg_data[smc_pkg::CFG_W-1:0];
        smc_pkg::CFG_LAMBDA_OVER_DT: lambda_over_dt <= cfg_data[smc_pkg::CFG_W-1:0];
        smc_pkg::CFG_K_STRONG:       k_strong       <= cfg_data[smc_pkg::CFG_W-1:0];
        smc_pkg::CFG_INV_PHI_STRONG: inv_phi_strong <= cfg_data[smc_pkg::CFG_W-1:0];
        smc_pkg::CFG_K_SOFT:         k_soft         <= cfg_data[smc_pkg::CFG_W-1:0];
        smc_pkg::CFG_INV_PHI_SOFT:   inv_phi_soft   <= cfg_data[smc_pkg::CFG_W-1:0];
        smc_pkg::CFG_DRIVE_LIMIT:    drive_limit    <= cfg_data[smc_pkg::CFG_W-1:0];
        smc_pkg::CFG_MAX_STEP:       max_step       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Error, saturated to 32 bits, and its magnitude.
  always_comb begin
    diff = {t_r[31], t_r} - {m_r[31], m_r};
    if (diff[32] != diff[31]) begin
      err_sat = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_sat = diff[31:0];
    end
    emag = err_sat[31] ? (~err_sat + 32'd1) : err_sat;
  end

  // Error difference and sliding surface.
  always_comb begin
    de     = {err_r[31], err_r} - {prev_err[31], prev_err};
    de_mag = de[32] ? (~de + 33'd1) : de;
    term_s = de_neg_r ? -$signed({1'b0, p_rnd[63:16]}) : $signed({1'b0, p_rnd[63:16]});
    s_val  = {{17{err_r[31]}}, err_r} + term_s;
    smag   = s_val[48] ? (~s_val + 49'd1) : s_val;
  end

  // Gain set selection and boundary layer saturation.
  always_comb begin
    ip_sel = strong_r ? inv_phi_strong : inv_phi_soft;
    k_sel  = strong_r ? k_strong : k_soft;
    r_sat  = p_rnd[63:16];
    if (ip_zero_r) begin
      satm = s_zero_r ? '0 : smc_pkg::ONE_Q16[smc_pkg::SATM_W-1:0];
    end else if (s_big_r || (r_sat > 48'(smc_pkg::ONE_Q16))) begin
      satm = smc_pkg::ONE_Q16[smc_pkg::SATM_W-1:0];
    end else begin
      satm = r_sat[smc_pkg::SATM_W-1:0];
    end
  end

  // Gain term plus feedforward, ramp limit and clamp.
  always_comb begin
    g_s     = s_neg_r ? -$signed({2'b00, p_rnd[47:16]}) : $signed({2'b00, p_rnd[47:16]});
    drv_sum = g_s + {{2{ff_r[31]}}, ff_r};
    delta   = {drv_r[33], drv_r} - {{3{prev_drive[31]}}, prev_drive};
    dmag    = delta[34] ? (~delta + 35'd1) : delta;
    step_s  = delta[34] ? -$signed({2'b00, max_step}) : $signed({2'b00, max_step});
    lim_s   = $signed({3'b000, drive_limit});
    clamp_hit = 1'b1;
    if (drv_r > lim_s) begin
      drv_final = lim_s[31:0];
    end else if (drv_r < -lim_s) begin
      drv_final = -lim_s[31:0];
    end else begin
      drv_final = drv_r[31:0];
      clamp_hit = 1'b0;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, multiplier operands and input handshake.
  always_comb begin
    state_next  = state;
    mul_a       = '0;
    mul_b       = '0;
    in_ch.ready = 1'b0;
    unique case (state)
      smc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_next = smc_pkg::ST_ERR;
      end
      smc_pkg::ST_ERR: begin
        state_next = (emag <= smc_pkg::ERR_DEADZONE) ? smc_pkg::ST_RAMP : smc_pkg::ST_DIFF;
      end
      smc_pkg::ST_DIFF: begin
        mul_a      = {1'b0, lambda_over_dt};
        mul_b      = de_mag[31:0];
        state_next = smc_pkg::ST_SURF;
      end
      smc_pkg::ST_SURF: begin
        state_next = smc_pkg::ST_SAT;
      end
      smc_pkg::ST_SAT: begin
        mul_a      = {1'b0, ip_sel};
        mul_b      = smag_lo_r;
        state_next = smc_pkg::ST_SATR;
      end
      smc_pkg::ST_SATR: begin
        state_next = smc_pkg::ST_GAIN;
      end
      smc_pkg::ST_GAIN: begin
        mul_a      = {1'b0, k_sel};
        mul_b      = {{(smc_pkg::DATA_W-smc_pkg::SATM_W){1'b0}}, satm_r};
        state_next = smc_pkg::ST_DRIVE;
      end
      smc_pkg::ST_DRIVE: begin
        state_next = smc_pkg::ST_RAMP;
      end
      smc_pkg::ST_RAMP: begin
        state_next = smc_pkg::ST_CLAMP;
      end
      smc_pkg::ST_CLAMP: begin
        if (slot_free) state_next = smc_pkg::ST_IDLE;
      end
      default: state_next = smc_pkg::ST_IDLE;
    endcase
  end

  // Data path registers, loaded step by step.
  always_ff @(posedge clk) begin
    unique case (state)
      smc_pkg::ST_IDLE: begin
        if (in_accept) begin
          t_r  <= in_ch.target;
          m_r  <= in_ch.measure;
          ff_r <= in_ch.feedforward;
        end
      end
      smc_pkg::ST_ERR: begin
        err_r    <= err_sat;
        dead_r   <= (emag <= smc_pkg::ERR_DEADZONE);
        strong_r <= (emag > {1'b0, switch_level});
        drv_r    <= '0;
      end
      smc_pkg::ST_DIFF: begin
        de_neg_r <= de[32];
      end
      smc_pkg::ST_SURF: begin
        s_neg_r   <= s_val[48];
        s_zero_r  <= (s_val == '0);
        s_big_r   <= |smag[47:32];
        smag_lo_r <= smag[31:0];
      end
      smc_pkg::ST_SAT: begin
        ip_zero_r <= (ip_sel == '0);
      end
      smc_pkg::ST_SATR: begin
        satm_r <= satm;
      end
      smc_pkg::ST_GAIN: ;
      smc_pkg::ST_DRIVE: begin
        drv_r <= drv_sum;
      end
      smc_pkg::ST_RAMP: begin
        // The ramp is bypassed when the step register holds all ones.
        if ((max_step != smc_pkg::RAMP_OFF) && (dmag > {3'b000, max_step})) begin
          drv_r    <= {{2{prev_drive[31]}}, prev_drive} + step_s;
          ramped_r <= 1'b1;
        end else begin
          ramped_r <= 1'b0;
        end
      end
      smc_pkg::ST_CLAMP: ;
      default: ;
    endcase
  end

  // Controller state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err   <= '0;
      prev_drive <= '0;
      out_valid  <= 1'b0;
    end else begin
      if ((state == smc_pkg::ST_CLAMP) && slot_free) begin
        prev_err   <= err_r;
        prev_drive <= drv_final;
        out_valid  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Result payload; it holds while the transaction waits.
  always_ff @(posedge clk) begin
    if ((state == smc_pkg::ST_CLAMP) && slot_free) begin
      drive_q   <= drv_final;
      dead_q    <= dead_r;
      ramped_q  <= ramped_r;
      clamped_q <= clamp_hit;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.drive        = drive_q;
  assign out_ch.in_dead_band = dead_q;
  assign out_ch.ramp_limited = ramped_q;
  assign out_ch.clamped      = clamped_q;

endmodule

@@ tb/sliding_mode_controller_step_top_tb.sv @@
// ----------------------------------------------------------------------------
// Sliding-mode controller step testbench
// Drives samples into the controller through its valid/ready input channel
// and checks every drive result against a cycle-free predictor of the
// Q16.16 control law: error saturation, dead band, sliding surface,
// boundary layer, gain selection, ramp limit and output clamp. Runs a short
// directed set, then random phases under several register settings, with
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module sliding_mode_controller_step_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef longint          s64_t;
  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [smc_pkg::DATA_W-1:0] target;
    logic signed [smc_pkg::DATA_W-1:0] measure;
    logic signed [smc_pkg::DATA_W-1:0] feedforward;
  } sample_t;

  typedef struct packed {
    logic [smc_pkg::DATA_W-1:0] drive;
    logic                       in_dead_band;
    logic                       ramp_limited;
    logic                       clamped;
  } drive_res_t;

  localparam s64_t I32_MAX       = 64'sd2147483647;
  localparam s64_t I32_MIN       = -64'sd2147483648;
  localparam int   IDLE_PCT      = 13;
  localparam int   SETTLE_CYCLES = 16;
  localparam int   HOLD_CYCLES   = 400;
  localparam int   PHASES        = 12;
  localparam int   PHASE_ITEMS   = 150;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [smc_pkg::IDX_W-1:0]    cfg_index;
  logic [smc_pkg::DATA_W-1:0]   cfg_data;

  smc_in_if  in_ch ();
  smc_out_if out_ch ();

  sliding_mode_controller_step_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: register copies plus the error and drive memories.
  logic [smc_pkg::DATA_W-1:0]        ctl_reg [8];
  logic signed [smc_pkg::DATA_W-1:0] last_err;
  logic signed [smc_pkg::DATA_W-1:0] last_drive;

  sample_t    sample_q [$];
  drive_res_t drive_exp [$];
  int         mismatch_count = 0;
  bit         in_taken = 1'b0;
  bit         steady = 1'b0;
  bit         hold_go = 1'b0;
  bit         hold_off = 1'b0;
  s64_t       track_target = 0;

  // Clock generation.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic u64_t magnitude(s64_t v);
    return (v < 0) ? u64_t'(-v) : u64_t'(v);
  endfunction

  // Rescale by 2^-16, rounding half away from zero on the magnitude.
  function automatic u64_t round_q16(u64_t m);
    return (m + 64'd32768) >> 16;
  endfunction

  function automatic s64_t signed_mag(bit neg, u64_t m);
    return neg ? -s64_t'(m) : s64_t'(m);
  endfunction

  // Computes the expected drive result of one sample and advances the state.
  function automatic drive_res_t predict_drive(sample_t smp);
    s64_t       err, de, surf, drv, delta, lim;
    u64_t       emag, term, smag, satm, gain, k, ip, ms;
    bit         dead, hi_gain, ramped, clip;
    drive_res_t res;
    err    = s64_t'($signed(smp.target)) - s64_t'($signed(smp.measure));
    ramped = 1'b0;
    clip   = 1'b0;
    if (err > I32_MAX) err = I32_MAX;
    if (err < I32_MIN) err = I32_MIN;
    emag = magnitude(err);
    dead = (emag <= u64_t'(smc_pkg::ERR_DEADZONE));

    if (dead) begin
      drv = 0;
    end else begin
      de      = err - s64_t'(last_err);
      term    = round_q16(u64_t'(ctl_reg[smc_pkg::CFG_LAMBDA_OVER_DT]) * magnitude(de));
      surf    = err + signed_mag(de < 0, term);
      hi_gain = (emag > u64_t'(ctl_reg[smc_pkg::CFG_SWITCH_LEVEL]));
      k       = hi_gain ? u64_t'(ctl_reg[smc_pkg::CFG_K_STRONG])
                        : u64_t'(ctl_reg[smc_pkg::CFG_K_SOFT]);
      ip      = hi_gain ? u64_t'(ctl_reg[smc_pkg::CFG_INV_PHI_STRONG])
                        : u64_t'(ctl_reg[smc_pkg::CFG_INV_PHI_SOFT]);
      smag    = magnitude(surf);
      // A zero reciprocal width means a hard sign instead of a boundary layer.
      if (ip == 0) begin
        satm = (surf == 0) ? 64'd0 : u64_t'(smc_pkg::ONE_Q16);
      end else if (smag >= 64'h1_0000_0000) begin
        satm = u64_t'(smc_pkg::ONE_Q16);
      end else begin
        satm = round_q16(smag * ip);
        if (satm > u64_t'(smc_pkg::ONE_Q16)) satm = u64_t'(smc_pkg::ONE_Q16);
      end
      gain = round_q16(k * satm);
      drv  = signed_mag(surf < 0, gain) + s64_t'($signed(smp.feedforward));
    end

    // Ramp limit against the previous drive, unless disabled.
    if (ctl_reg[smc_pkg::CFG_MAX_STEP] != smc_pkg::RAMP_OFF) begin
      ms    = u64_t'(ctl_reg[smc_pkg::CFG_MAX_STEP]);
      delta = drv - s64_t'(last_drive);
      if (magnitude(delta) > ms) begin
        drv    = s64_t'(last_drive) + signed_mag(delta < 0, ms);
        ramped = 1'b1;
      end
    end

    // Symmetric output clamp.
    lim = s64_t'(ctl_reg[smc_pkg::CFG_DRIVE_LIMIT]);
    if (drv > lim) begin
      drv  = lim;
      clip = 1'b1;
    end else if (drv < -lim) begin
      drv  = -lim;
      clip = 1'b1;
    end

    last_err   = err[smc_pkg::DATA_W-1:0];
    last_drive = drv[smc_pkg::DATA_W-1:0];

    res.drive        = drv[smc_pkg::DATA_W-1:0];
    res.in_dead_band = dead;
    res.ramp_limited = ramped;
    res.clamped      = clip;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [smc_pkg::DATA_W-1:0] got,
                                 logic [smc_pkg::DATA_W-1:0] want);
    mismatch_count++;
    $display("[%0t] mismatch #%0d on %s: got %h, expected %h",
             $realtime, mismatch_count, field, got, want);
  endtask

  // Writes one register at the falling edge and mirrors it in the predictor.
  task automatic write_reg(smc_pkg::cfg_idx_t idx, logic [smc_pkg::DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ctl_reg[idx] = (idx == smc_pkg::CFG_MAX_STEP) ? val : {1'b0, val[smc_pkg::CFG_W-1:0]};
  endtask

  function automatic logic [smc_pkg::DATA_W-1:0] pick_reg_value();
    logic [smc_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 6))
      0:       v = '0;
      1:       v = '1;
      2:       v = $urandom;
      3:       v = $urandom_range(0, 32'h0002_0000);
      4:       v = $urandom_range(32'h0000_8000, 32'h0001_8000);
      5:       v = $urandom_range(0, 32'h0010_0000);
      default: v = {1'($urandom_range(0, 1)), 31'h0} | $urandom_range(0, 32'h0100_0000);
    endcase
    return v;
  endfunction

  task automatic put_sample(logic [smc_pkg::DATA_W-1:0] t, logic [smc_pkg::DATA_W-1:0] m,
                            logic [smc_pkg::DATA_W-1:0] f);
    sample_t smp;
    smp.target      = t;
    smp.measure     = m;
    smp.feedforward = f;
    sample_q.push_back(smp);
  endtask

  // Mostly a drifting setpoint tracked closely, plus dead-band probes and noise.
  task automatic put_random_sample();
    int   kind;
    s64_t off, ff;
    kind = $urandom_range(0, 99);
    ff   = ($urandom_range(0, 1) != 0) ? s64_t'($signed(32'($urandom)))
                                       : s64_t'($urandom_range(0, 32'h0008_0000)) - 64'sh4_0000;
    if (kind < 30) begin
      put_sample($urandom, $urandom, ff[smc_pkg::DATA_W-1:0]);
    end else begin
      track_target = track_target + s64_t'($urandom_range(0, 32'h0004_0000)) - 64'sh2_0000;
      if (kind < 50)
        off = s64_t'($urandom_range(0, 1400)) - 700;
      else
        off = s64_t'($urandom_range(0, 32'h1 << $urandom_range(8, 24)));
      if ($urandom_range(0, 1) != 0) off = -off;
      put_sample(track_target[smc_pkg::DATA_W-1:0],
                 track_target[smc_pkg::DATA_W-1:0] - off[smc_pkg::DATA_W-1:0],
                 ff[smc_pkg::DATA_W-1:0]);
    end
  endtask

  // Waits until every sample is taken and every result has come back.
  task automatic drain();
    while (sample_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (drive_exp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input driver: offers the next pending sample, idling at random.
  always @(negedge clk) begin : sample_driver
    sample_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (sample_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = sample_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.target      <= nxt.target;
        in_ch.measure     <= nxt.measure;
        in_ch.feedforward <= nxt.feedforward;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Each input transaction produces one expected result.
  always @(posedge clk) begin : sample_accept
    sample_t got;
    in_taken = !rst && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      got.target      = in_ch.target;
      got.measure     = in_ch.measure;
      got.feedforward = in_ch.feedforward;
      drive_exp.push_back(predict_drive(got));
    end
  end

  // Receiver ready: random stalls, or a long hold-off when requested.
  always @(negedge clk) begin : result_ready
    if (rst || hold_off)
      out_ch.ready <= 1'b0;
    else if (steady)
      out_ch.ready <= 1'b1;
    else
      out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Result monitor: each output transaction against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    drive_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (drive_exp.size() == 0) begin
        report_mismatch("unexpected result", out_ch.drive, '0);
      end else begin
        want = drive_exp.pop_front();
        if (out_ch.drive !== want.drive)
          report_mismatch("drive", out_ch.drive, want.drive);
        if (out_ch.in_dead_band !== want.in_dead_band)
          report_mismatch("in_dead_band", 32'(out_ch.in_dead_band), 32'(want.in_dead_band));
        if (out_ch.ramp_limited !== want.ramp_limited)
          report_mismatch("ramp_limited", 32'(out_ch.ramp_limited), 32'(want.ramp_limited));
        if (out_ch.clamped !== want.clamped)
          report_mismatch("clamped", 32'(out_ch.clamped), 32'(want.clamped));
      end
    end
  end

  // Long receiver hold-off so that the block fills and stalls its input.
  initial begin : receiver_hold_off
    wait (hold_go);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Overall time limit.
  initial begin : run_limit
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus sequence.
  initial begin : stimulus
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = smc_pkg::CFG_SWITCH_LEVEL;
    cfg_data          = '0;

    ctl_reg[smc_pkg::CFG_SWITCH_LEVEL]   = smc_pkg::RST_SWITCH_LEVEL;
    ctl_reg[smc_pkg::CFG_LAMBDA_OVER_DT] = smc_pkg::RST_LAMBDA_OVER_DT;
    ctl_reg[smc_pkg::CFG_K_STRONG]       = smc_pkg::RST_K_STRONG;
    ctl_reg[smc_pkg::CFG_INV_PHI_STRONG] = smc_pkg::RST_INV_PHI_STRONG;
    ctl_reg[smc_pkg::CFG_K_SOFT]         = smc_pkg::RST_K_SOFT;
    ctl_reg[smc_pkg::CFG_INV_PHI_SOFT]   = smc_pkg::RST_INV_PHI_SOFT;
    ctl_reg[smc_pkg::CFG_DRIVE_LIMIT]    = smc_pkg::RST_DRIVE_LIMIT;
    ctl_reg[smc_pkg::CFG_MAX_STEP]       = smc_pkg::RST_MAX_STEP;
    last_err   = '0;
    last_drive = '0;

    // Directed samples under reset settings: dead band edges, overflow,
    // feedforward extremes, the strong/soft boundary and a repeated error.
    put_sample(32'd0, 32'd0, 32'd0);
    put_sample(32'd655, 32'd0, 32'd0);
    put_sample(32'd656, 32'd0, 32'd0);
    put_sample(32'd0, 32'd655, 32'd0);
    put_sample(32'd0, 32'd656, 32'd0);
    put_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    put_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    put_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    put_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    put_sample(32'h0001_0000, 32'd0, 32'h7FFF_FFFF);
    put_sample(32'h0001_0001, 32'd0, 32'd0);
    put_sample(32'd0, 32'd0, 32'h8000_0000);
    put_sample(32'd5000, 32'd0, 32'd0);
    put_sample(32'd5000, 32'd0, 32'd0);
    put_sample(32'hFFFF_0000, 32'h0000_1000, 32'h0000_4000);

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    drain();

    // Hard sign: positive, zero and negative sliding variable.
    write_reg(smc_pkg::CFG_INV_PHI_STRONG, '0);
    write_reg(smc_pkg::CFG_INV_PHI_SOFT, '0);
    @(posedge clk);
    put_sample(32'd2000, 32'd0, 32'd0);
    put_sample(32'd1000, 32'd0, 32'd0);
    put_sample(32'd0, 32'd3000, 32'd0);
    put_sample(32'h0004_0000, 32'd0, 32'd0);
    drain();

    // Zero ramp step and zero output limit, then finite values of both.
    write_reg(smc_pkg::CFG_MAX_STEP, '0);
    write_reg(smc_pkg::CFG_DRIVE_LIMIT, '0);
    @(posedge clk);
    put_sample(32'h0010_0000, 32'd0, 32'h0100_0000);
    put_sample(32'd0, 32'h0010_0000, 32'h8000_0000);
    drain();
    write_reg(smc_pkg::CFG_MAX_STEP, 32'h0001_0000);
    write_reg(smc_pkg::CFG_DRIVE_LIMIT, 32'h0003_0000);
    @(posedge clk);
    put_sample(32'h0020_0000, 32'd0, 32'h0100_0000);
    put_sample(32'h0020_0000, 32'd0, 32'h0100_0000);
    put_sample(32'd0, 32'h0020_0000, 32'hFF00_0000);
    drain();

    // Random phases, each under a fresh register setting.
    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < 8; i++) begin
        if (p == 0)
          write_reg(smc_pkg::cfg_idx_t'(i), '1);
        else if (p == 1)
          write_reg(smc_pkg::cfg_idx_t'(i), '0);
        else if (p == 2)
          write_reg(smc_pkg::cfg_idx_t'(i), (i == smc_pkg::CFG_MAX_STEP) ?
                    smc_pkg::RAMP_OFF : 32'(smc_pkg::ONE_Q16));
        else
          write_reg(smc_pkg::cfg_idx_t'(i), pick_reg_value());
      end
      @(posedge clk);
      steady  = (p == 4);
      if (p == 6) hold_go = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) put_random_sample();
      drain();
      steady = 1'b0;
    end

    if (mismatch_count == 0 && drive_exp.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
